// ===== hdl/aprd_pkg.sv =====
// Package for the peak/RMS waveform decimator: sizes, register indexes,
// the job word handed from front to back, and back-end state codes. No dependencies.
package aprd_pkg;
    localparam int MAX_CHANNELS = 8;
    localparam int SAMPLE_BITS  = 16;
    localparam int CH_BITS      = 3;
    localparam int CNT_BITS     = 4;
    localparam int FRAME_BITS   = 16;
    localparam int HIGH_BITS    = 15;
    localparam int SUM_BITS     = 46;
    localparam int MEAN_BITS    = 32;
    localparam int RMS_BITS     = 16;
    localparam int IDX_BITS     = 8;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 56;

    localparam logic [IDX_BITS-1:0] REG_CHANNEL_COUNT    = 8'd0;
    localparam logic [IDX_BITS-1:0] REG_FRAMES_PER_POINT = 8'd1;
    localparam logic [CNT_BITS-1:0]   RESET_CHANNEL_COUNT    = 4'd2;
    localparam logic [FRAME_BITS-1:0] RESET_FRAMES_PER_POINT = 16'd100;

    typedef struct packed {
        logic [CH_BITS-1:0]          channel;
        logic [HIGH_BITS-1:0]        peak_high;
        logic signed [SAMPLE_BITS-1:0] peak_low;
        logic [SUM_BITS-1:0]         square_sum;
        logic [FRAME_BITS-1:0]       frames;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT,
        ST_OUT
    } t_back_state;
endpackage

// ===== hdl/audio_peak_rms_decimator.sv =====
// Peak/RMS waveform decimator top level: front end, job queue, back end.
// Samples are taken one a cycle while the two-entry job queue has room.
// A completed point is queued at its sample's accepting edge, taken by the back end
// once that is idle, then passes the bit-serial divider and the square-root loop before
// the word shows. The back end works on one point at a time; the queue holds the rest.
// Synchronous active-low reset restores register defaults and clears the channel stores;
// it also empties the job queue.
module audio_peak_rms_decimator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [aprd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [15:0] sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] channel, [17:3] peak_high, [33:18] peak_low, [49:34] rms_level, rest zero
    output logic [aprd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [aprd_pkg::IDX_BITS-1:0]    i_cfg_index,
    input  logic [aprd_pkg::FRAME_BITS-1:0]  i_cfg_data
);
    import aprd_pkg::*;

    t_job         push_job, pop_job;
    t_fifo_status fifo_status;
    logic         push, pop;
    logic [CH_BITS-1:0]   channel;
    logic [HIGH_BITS-1:0] peak_high;
    logic signed [SAMPLE_BITS-1:0] peak_low;
    logic [RMS_BITS-1:0]  rms_level;

    assign o_cfg_ready = 1'b1;

    aprd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_sample      (s_axis_tdata),
        .i_cfg_write   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_fifo_status (fifo_status),
        .o_push        (push),
        .o_job         (push_job)
    );

    aprd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (pop_job),
        .o_status (fifo_status)
    );

    aprd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (pop_job),
        .i_fifo_status (fifo_status),
        .o_pop         (pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_channel     (channel),
        .o_peak_high   (peak_high),
        .o_peak_low    (peak_low),
        .o_rms_level   (rms_level)
    );

    assign m_axis_tdata = {6'd0, rms_level, peak_low, peak_high, channel};
endmodule

// ===== hdl/aprd_front.sv =====
// Front end: takes samples, updates per-channel peak and square-sum stores,
// hands a job word to the queue when a channel's block completes. Uses aprd_pkg.
module aprd_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [aprd_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                            i_cfg_write,
    input  logic [aprd_pkg::IDX_BITS-1:0]   i_cfg_index,
    input  logic [aprd_pkg::FRAME_BITS-1:0] i_cfg_data,
    input  aprd_pkg::t_fifo_status          i_fifo_status,
    output logic                            o_push,
    output aprd_pkg::t_job                  o_job
);
    import aprd_pkg::*;

    logic [CNT_BITS-1:0]   r_channel_count;
    logic [FRAME_BITS-1:0] r_frames_per_point;
    logic [HIGH_BITS-1:0]  r_high [MAX_CHANNELS];
    logic signed [SAMPLE_BITS-1:0] r_low [MAX_CHANNELS];
    logic [SUM_BITS-1:0]   r_sum [MAX_CHANNELS];
    logic [CH_BITS-1:0]    r_chan_pos;
    logic [FRAME_BITS-1:0] r_frame_pos;

    logic [CNT_BITS-1:0]   chans;
    logic [FRAME_BITS-1:0] frames;
    logic [CH_BITS-1:0]    ch;
    logic                  accept, frame_done, last_chan, cfg_hit;
    logic signed [SAMPLE_BITS:0] high_ext;
    logic [HIGH_BITS-1:0]  n_high;
    logic signed [SAMPLE_BITS-1:0] n_low;
    logic [SAMPLE_BITS:0]  mag;
    logic [2*SAMPLE_BITS-1:0] square;
    logic [SUM_BITS-1:0]   n_sum;

    always_comb begin
        if (r_channel_count == '0) begin
            chans = CNT_BITS'(1);
        end else if (r_channel_count > CNT_BITS'(MAX_CHANNELS)) begin
            chans = CNT_BITS'(MAX_CHANNELS);
        end else begin
            chans = r_channel_count;
        end
        frames = (r_frames_per_point == '0) ? FRAME_BITS'(1) : r_frames_per_point;
        ch = ({1'b0, r_chan_pos} >= chans) ? '0 : r_chan_pos;
        accept     = i_valid && o_ready;
        frame_done = ({1'b0, r_frame_pos} + 17'd1) >= {1'b0, frames};
        last_chan  = ({1'b0, ch} + CNT_BITS'(1)) >= chans;
        cfg_hit    = i_cfg_write &&
                     (i_cfg_index == REG_CHANNEL_COUNT || i_cfg_index == REG_FRAMES_PER_POINT);

        high_ext = $signed({2'b00, r_high[ch]});
        n_high   = (i_sample > high_ext) ? i_sample[HIGH_BITS-1:0] : r_high[ch];
        n_low    = (i_sample < r_low[ch]) ? i_sample : r_low[ch];
        mag      = i_sample[SAMPLE_BITS-1] ? (SAMPLE_BITS+1)'(-$signed({i_sample[SAMPLE_BITS-1],
                   i_sample})) : {1'b0, i_sample};
        square   = (2*SAMPLE_BITS)'(mag * mag);
        n_sum    = r_sum[ch] + SUM_BITS'(square);
    end

    assign o_ready = !i_fifo_status.full;
    assign o_push  = accept && frame_done;
    always_comb begin
        o_job.channel    = ch;
        o_job.peak_high  = n_high;
        o_job.peak_low   = n_low;
        o_job.square_sum = n_sum;
        o_job.frames     = frames;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            if (!i_rst_n) begin
                r_channel_count    <= RESET_CHANNEL_COUNT;
                r_frames_per_point <= RESET_FRAMES_PER_POINT;
            end else if (i_cfg_index == REG_CHANNEL_COUNT) begin
                r_channel_count <= i_cfg_data[CNT_BITS-1:0];
            end else begin
                r_frames_per_point <= i_cfg_data;
            end
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_high[i] <= '0;
                r_low[i]  <= '0;
                r_sum[i]  <= '0;
            end
            r_chan_pos  <= '0;
            r_frame_pos <= '0;
        end else if (accept) begin
            // clear the channel's accumulators once its point is out
            r_high[ch] <= frame_done ? '0 : n_high;
            r_low[ch]  <= frame_done ? '0 : n_low;
            r_sum[ch]  <= frame_done ? '0 : n_sum;
            if (last_chan) begin
                r_chan_pos  <= '0;
                r_frame_pos <= frame_done ? '0 : r_frame_pos + FRAME_BITS'(1);
            end else begin
                r_chan_pos <= ch + CH_BITS'(1);
            end
        end
    end
endmodule

// ===== hdl/aprd_fifo.sv =====
// Two-entry job queue between front and back end. Uses aprd_pkg.
module aprd_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  aprd_pkg::t_job         i_job,
    input  logic                   i_pop,
    output aprd_pkg::t_job         o_job,
    output aprd_pkg::t_fifo_status o_status
);
    import aprd_pkg::*;

    t_job       r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    assign o_job           = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == 2'd2);
    assign o_status.empty  = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= !r_wr_ptr;
            if (i_pop)  r_rd_ptr <= !r_rd_ptr;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

// ===== hdl/aprd_back.sv =====
// Back end: divides a job's square sum by the frame count one bit a cycle,
// takes the integer square root of the mean, two bits of it a cycle, holds the result word. Uses aprd_pkg.
module aprd_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  aprd_pkg::t_job         i_job,
    input  aprd_pkg::t_fifo_status i_fifo_status,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [aprd_pkg::CH_BITS-1:0]   o_channel,
    output logic [aprd_pkg::HIGH_BITS-1:0] o_peak_high,
    output logic signed [aprd_pkg::SAMPLE_BITS-1:0] o_peak_low,
    output logic [aprd_pkg::RMS_BITS-1:0]  o_rms_level
);
    import aprd_pkg::*;

    t_back_state r_state, n_state;
    logic [CH_BITS-1:0]   r_channel, n_channel;
    logic [HIGH_BITS-1:0] r_high, n_high;
    logic signed [SAMPLE_BITS-1:0] r_low, n_low;
    logic [FRAME_BITS-1:0] r_div, n_div;
    logic [SUM_BITS-1:0]  r_num, n_num;
    logic [FRAME_BITS-1:0] r_rem, n_rem;
    logic [5:0]           r_step, n_step;
    logic [MEAN_BITS-1:0] r_n, n_n, r_root, n_root, r_bit, n_bit;

    logic [FRAME_BITS:0]  trial;
    logic [MEAN_BITS-1:0] cand;

    always_comb begin
        n_state   = r_state;
        n_channel = r_channel;
        n_high    = r_high;
        n_low     = r_low;
        n_div     = r_div;
        n_num     = r_num;
        n_rem     = r_rem;
        n_step    = r_step;
        n_n       = r_n;
        n_root    = r_root;
        n_bit     = r_bit;
        o_pop     = 1'b0;
        trial     = {r_rem, r_num[SUM_BITS-1]};
        cand      = r_root + r_bit;
        case (r_state)
            ST_IDLE: begin
                if (!i_fifo_status.empty) begin
                    o_pop     = 1'b1;
                    n_channel = i_job.channel;
                    n_high    = i_job.peak_high;
                    n_low     = i_job.peak_low;
                    n_div     = i_job.frames;
                    n_num     = i_job.square_sum;
                    n_rem     = '0;
                    n_step    = 6'(SUM_BITS - 1);
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                // shift quotient bits into the low end of the dividend
                if (trial >= {1'b0, r_div}) begin
                    n_rem = FRAME_BITS'(trial - {1'b0, r_div});
                    n_num = {r_num[SUM_BITS-2:0], 1'b1};
                end else begin
                    n_rem = trial[FRAME_BITS-1:0];
                    n_num = {r_num[SUM_BITS-2:0], 1'b0};
                end
                n_step = r_step - 6'd1;
                if (r_step == '0) begin
                    n_n     = n_num[MEAN_BITS-1:0];
                    n_root  = '0;
                    n_bit   = MEAN_BITS'(1) << (MEAN_BITS - 2);
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (r_n >= cand) begin
                    n_n    = r_n - cand;
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit[0]) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_valid     = (r_state == ST_OUT);
    assign o_channel   = r_channel;
    assign o_peak_high = r_high;
    assign o_peak_low  = r_low;
    assign o_rms_level = r_root[RMS_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_channel <= n_channel;
        r_high    <= n_high;
        r_low     <= n_low;
        r_div     <= n_div;
        r_num     <= n_num;
        r_rem     <= n_rem;
        r_step    <= n_step;
        r_n       <= n_n;
        r_root    <= n_root;
        r_bit     <= n_bit;
    end
endmodule

// ===== tb/audio_peak_rms_decimator_tb.sv =====
// Testbench for the peak/RMS waveform decimator: drives sample streams over
// several register settings and checks every waveform point against a predictor.
// Depends on aprd_pkg and audio_peak_rms_decimator.
`timescale 1ns / 100ps

module audio_peak_rms_decimator_tb;
    import aprd_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;

    typedef struct packed {
        logic [CH_BITS-1:0]            channel;
        logic [HIGH_BITS-1:0]          peak_high;
        logic signed [SAMPLE_BITS-1:0] peak_low;
        logic [RMS_BITS-1:0]           rms_level;
    } t_point;

    // one directed row: sample, and an optional typed-in point
    typedef struct {
        logic signed [15:0] sample;
        bit                 has_point;
        t_point             point;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [IDX_BITS-1:0]   i_cfg_index = '0;
    logic [FRAME_BITS-1:0] i_cfg_data = '0;

    audio_peak_rms_decimator dut (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [CNT_BITS-1:0]   chan_reg;
    logic [FRAME_BITS-1:0] frame_reg;
    logic [HIGH_BITS-1:0]          hi_acc [MAX_CHANNELS];
    logic signed [SAMPLE_BITS-1:0] lo_acc [MAX_CHANNELS];
    logic [SUM_BITS-1:0]           sq_acc [MAX_CHANNELS];
    int unsigned chan_pos, frame_pos;

    t_point pending_points[$];
    int     errors = 0;
    int     cycles = 0;
    bit     quiet = 1'b0;

    function automatic logic [RMS_BITS-1:0] floor_sqrt(logic [SUM_BITS-1:0] n);
        logic [63:0] rem, root, bitv;
        rem = n;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root[RMS_BITS-1:0];
    endfunction

    task automatic clear_points_state();
        for (int c = 0; c < MAX_CHANNELS; c++) begin
            hi_acc[c] = '0;
            lo_acc[c] = '0;
            sq_acc[c] = '0;
        end
        chan_pos = 0;
        frame_pos = 0;
    endtask

    task automatic predict_config(logic [IDX_BITS-1:0] idx, logic [FRAME_BITS-1:0] val);
        if (idx == REG_CHANNEL_COUNT) begin
            chan_reg = val[CNT_BITS-1:0];
            clear_points_state();
        end else if (idx == REG_FRAMES_PER_POINT) begin
            frame_reg = val;
            clear_points_state();
        end
    endtask

    // returns 1 when the sample closes a block
    function automatic bit predict_point(logic signed [15:0] s, output t_point p);
        int unsigned nch, nfr, ch;
        logic [31:0] mag;
        bit done;
        nch = (chan_reg == 0) ? 1 : (chan_reg > MAX_CHANNELS ? MAX_CHANNELS : chan_reg);
        nfr = (frame_reg == 0) ? 1 : frame_reg;
        ch = (chan_pos >= nch) ? 0 : chan_pos;
        if (s > $signed({1'b0, hi_acc[ch]})) hi_acc[ch] = s[14:0];
        if (s < lo_acc[ch]) lo_acc[ch] = s;
        mag = (s < 0) ? -$signed({{16{s[15]}}, s}) : {16'd0, s};
        sq_acc[ch] += mag * mag;
        done = (frame_pos + 1 >= nfr);
        p = '0;
        if (done) begin
            p.channel = ch[CH_BITS-1:0];
            p.peak_high = hi_acc[ch];
            p.peak_low = lo_acc[ch];
            p.rms_level = floor_sqrt(sq_acc[ch] / nfr);
            hi_acc[ch] = '0;
            lo_acc[ch] = '0;
            sq_acc[ch] = '0;
        end
        if (ch + 1 >= nch) begin
            chan_pos = 0;
            frame_pos = done ? 0 : frame_pos + 1;
        end else begin
            chan_pos = ch + 1;
        end
        return done;
    endfunction

    // output side: random stalls, check each point word
    always @(posedge i_clk) begin
        t_point got, want;
        cycles <= cycles + 1;
        if (m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[2:0], m_axis_tdata[17:3], m_axis_tdata[33:18],
                    m_axis_tdata[49:34]};
            if (pending_points.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time, got);
                errors++;
            end else begin
                want = pending_points.pop_front();
                if (got.channel !== want.channel || got.peak_high !== want.peak_high ||
                    got.peak_low !== want.peak_low || got.rms_level !== want.rms_level ||
                    m_axis_tdata[55:50] !== '0) begin
                    $display("%0t: mismatch, expected ch %0d hi %0d lo %0d rms %0d, ",
                             $time, want.channel, want.peak_high, want.peak_low,
                             want.rms_level,
                             "actual ch %0d hi %0d lo %0d rms %0d",
                             got.channel, got.peak_high, got.peak_low, got.rms_level);
                    errors++;
                end
            end
        end
    end

    initial begin
        int gap;
        forever begin
            @(negedge i_clk);
            if (quiet || $urandom_range(0, 3) != 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                gap = $urandom_range(1, 19);
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    end

    initial begin
        @(posedge i_clk);
        while (cycles < LIMIT_CYCLES) @(posedge i_clk);
        $display("Some tests failed");
        $finish;
    end

    task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [FRAME_BITS-1:0] val);
        // hold the sample side idle and let the back end drain a point still in flight
        s_axis_tvalid <= 1'b0;
        while (pending_points.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        predict_config(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // drive one sample; the point is predicted at acceptance
    task automatic send_sample(logic signed [15:0] s, bit idle_ok);
        t_point p;
        if (idle_ok && !quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= s;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (predict_point(s, p)) pending_points = {pending_points, p};
        @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return $signed(16'($urandom_range(0, 15)) - 16'sd8);
            default: return $signed(16'($urandom));
        endcase
    endfunction

    initial begin
        t_row rows[6];
        t_point p;
        int     sent;
        logic [FRAME_BITS-1:0] fsel;
        chan_reg = RESET_CHANNEL_COUNT;
        frame_reg = RESET_FRAMES_PER_POINT;
        clear_points_state();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset defaults: two channels, 100 frames; a full block of zeros
        for (int k = 0; k < 200; k++) send_sample(16'sd0, 1'b0);

        // one channel, one frame: each sample is a point of its own
        write_reg(REG_CHANNEL_COUNT, 16'd1);
        write_reg(REG_FRAMES_PER_POINT, 16'd1);
        rows = '{
            '{16'sh7FFF, 1'b1, '{3'd0, 15'h7FFF, 16'sd0, 16'd32767}},
            '{16'sh8000, 1'b1, '{3'd0, 15'd0, 16'sh8000, 16'd32768}},
            '{16'sd0,    1'b1, '{3'd0, 15'd0, 16'sd0, 16'd0}},
            '{16'sd1,    1'b1, '{3'd0, 15'd1, 16'sd0, 16'd1}},
            '{-16'sd1,   1'b1, '{3'd0, 15'd0, -16'sd1, 16'd1}},
            '{16'sd5,    1'b0, '0}
        };
        foreach (rows[r]) begin
            send_sample(rows[r].sample, 1'b0);
            if (rows[r].has_point && pending_points[$] !== rows[r].point) begin
                $display("%0t: table row %0d, expected %h, actual prediction %h",
                         $time, r, rows[r].point, pending_points[$]);
                errors++;
            end
        end
        // zero frames and zero channels act as one
        write_reg(REG_FRAMES_PER_POINT, 16'd0);
        write_reg(REG_CHANNEL_COUNT, 16'd0);
        send_sample(16'sh1234, 1'b0);
        send_sample(-16'sh4321, 1'b0);
        // channel count above the maximum saturates
        write_reg(REG_CHANNEL_COUNT, 16'd15);
        write_reg(REG_FRAMES_PER_POINT, 16'd2);
        for (int k = 0; k < 16; k++) send_sample(rand_sample(), 1'b0);
        // unknown index: ignored, nothing cleared
        send_sample(16'sh0100, 1'b0);
        write_reg(8'd7, 16'd3);
        write_reg(8'hFF, 16'hFFFF);
        for (int k = 0; k < 15; k++) send_sample(rand_sample(), 1'b0);

        // random phases over several settings
        sent = 0;
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(REG_CHANNEL_COUNT, 16'($urandom_range(0, 15)));
            case ($urandom_range(0, 4))
                0: fsel = 16'd1;
                1: fsel = 16'd0;
                default: fsel = 16'($urandom_range(2, 12));
            endcase
            write_reg(REG_FRAMES_PER_POINT, fsel);
            if (ph >= 10) quiet = 1'b1;
            for (int k = 0; k < 25; k++) send_sample(rand_sample(), 1'b1);
            sent += 25;
        end
        s_axis_tvalid <= 1'b0;

        while (pending_points.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hdl/aprd_pkg.sv
hdl/aprd_front.sv
hdl/aprd_fifo.sv
hdl/aprd_back.sv
hdl/audio_peak_rms_decimator.sv
tb/audio_peak_rms_decimator_tb.sv
